// ----- hw/rtl/stg_pkg.sv -----
// Package for the stepper tone generator core.
// Holds field widths, request codes and parameter defaults.
// No dependencies.
package stg_pkg;

    localparam int TIME_WIDTH_DEF        = 20;
    localparam int STEP_COUNT_WIDTH_DEF  = 16;

    localparam int REQ_W    = 2;
    localparam int ELAPSED_W = 16;
    localparam int PITCH_W  = 7;
    localparam int VEL_W    = 7;
    localparam int PERIOD_W = 20;
    localparam int HALF_W   = PERIOD_W - 1;
    localparam int POS_W    = 8;

    localparam logic [POS_W-1:0] TRACK_POSITIONS_RESET = 8'd80;

    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd2;

endpackage

// ----- hw/rtl/stepper_tone_generator_with_bounce_core.sv -----
// Stepper tone generator core: tick / note-on / note-off items in, head state out.
// Depends on stg_pkg.
//
// An item is taken when s_ready is high, and one result item follows per input item.
// A tick that toggles the step level under a nonzero half period passes through the
// remainder state, which works out the remainder of the time sum by the half period on
// one shared subtract-compare unit, one dividend bit per cycle; every other item goes
// from execute to done. The result register lets the next item in while the previous
// result waits on m_ready. The user must write the track count through cfg_we/cfg_wdata
// only while the core is idle; the core itself does not enforce this.
module stepper_tone_generator_with_bounce_core #(
    parameter int TIME_WIDTH       = stg_pkg::TIME_WIDTH_DEF,
    parameter int STEP_COUNT_WIDTH = stg_pkg::STEP_COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic [stg_pkg::POS_W-1:0]    cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [stg_pkg::REQ_W-1:0]    s_req_type,
    input  logic [stg_pkg::ELAPSED_W-1:0] s_elapsed_time,
    input  logic [stg_pkg::PITCH_W-1:0]  s_note_pitch,
    input  logic [stg_pkg::VEL_W-1:0]    s_velocity,
    input  logic [stg_pkg::PERIOD_W-1:0] s_note_period,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_step_level,
    output logic                         m_direction_level,
    output logic [stg_pkg::POS_W-1:0]    m_head_position,
    output logic                         m_sounding,
    output logic [stg_pkg::PITCH_W-1:0]  m_playing_pitch
);

    localparam int HW    = stg_pkg::HALF_W;
    localparam int PW    = stg_pkg::POS_W;
    localparam int CMP_W = (TIME_WIDTH > HW) ? TIME_WIDTH : HW;
    localparam int CNT_W = $clog2(TIME_WIDTH);
    localparam int RW    = STEP_COUNT_WIDTH + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // latched item
    logic [stg_pkg::REQ_W-1:0]     req_reg;
    logic [stg_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [stg_pkg::PITCH_W-1:0]   pitch_in_reg;
    logic [stg_pkg::VEL_W-1:0]     vel_reg;
    logic [HW-1:0]                 half_in_reg;

    // tone state
    logic [PW-1:0]               tp_reg;
    logic                        phase_reg, phase_next;
    logic                        dir_reg, dir_next;
    logic [PW-1:0]               pos_reg, pos_next;
    logic                        active_reg, active_next;
    logic [stg_pkg::PITCH_W-1:0] pitch_reg, pitch_next;
    logic [HW-1:0]               half_reg, half_next;
    logic [TIME_WIDTH-1:0]       accum_reg, accum_next;
    logic [STEP_COUNT_WIDTH-1:0] count_reg, count_next;

    // remainder sequencer
    logic [CMP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] bit_reg, bit_next;

    // result register
    logic                        m_valid_reg;
    logic                        m_step_reg;
    logic                        m_dir_reg;
    logic [PW-1:0]               m_pos_reg;
    logic                        m_sounding_reg;
    logic [stg_pkg::PITCH_W-1:0] m_pitch_reg;
    logic                        out_load;

    // saturating time sum
    logic [TIME_WIDTH:0]   sum_wide;
    logic [TIME_WIDTH-1:0] sum_sat;

    // shared subtract-compare unit
    logic [CMP_W:0] unit_a;
    logic [CMP_W:0] unit_b;
    logic [CMP_W:0] unit_diff;
    logic           unit_ge;
    logic [CMP_W:0] trial;

    // step toggle
    logic       at_end;
    logic       tog_dir;
    logic       tog_phase;
    logic [PW-1:0] tog_pos;
    logic [STEP_COUNT_WIDTH-1:0] tog_count;

    // note-off bounce decision
    logic signed [RW-1:0] tp_s;
    logic signed [RW-1:0] pos_s;
    logic signed [RW-1:0] room_s;
    logic signed [RW-1:0] saved_s;
    logic                 flip_off;
    logic                 is_off;
    logic                 off_match;

    assign s_ready = (state_reg == ST_IDLE);

    assign sum_wide = {1'b0, accum_reg} + (TIME_WIDTH + 1)'(elapsed_reg);
    assign sum_sat  = sum_wide[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum_wide[TIME_WIDTH-1:0];

    assign trial     = {rem_reg, accum_reg[TIME_WIDTH-1]};
    assign unit_a    = (state_reg == ST_DIV) ? trial : (CMP_W + 1)'(sum_sat);
    assign unit_b    = (CMP_W + 1)'(half_reg);
    assign unit_ge   = (unit_a >= unit_b);
    assign unit_diff = unit_a - unit_b;

    // direction reverses when the head already sits at the end it moves toward
    assign at_end    = dir_reg ? (({1'b0, pos_reg} + 9'd1) >= {1'b0, tp_reg})
                               : (pos_reg == '0);
    assign tog_dir   = dir_reg ^ at_end;
    assign tog_phase = ~phase_reg;

    always_comb begin
        tog_pos   = pos_reg;
        tog_count = count_reg;
        if (tog_phase) begin
            if (count_reg != {STEP_COUNT_WIDTH{1'b1}}) begin
                tog_count = count_reg + 1'b1;
            end
            if (tog_dir) begin
                if (pos_reg != {PW{1'b1}}) begin
                    tog_pos = pos_reg + 1'b1;
                end
            end else begin
                if (pos_reg != '0) begin
                    tog_pos = pos_reg - 1'b1;
                end
            end
        end
    end

    assign tp_s    = $signed(RW'(tp_reg));
    assign pos_s   = $signed(RW'(pos_reg));
    assign room_s  = dir_reg ? (tp_s - pos_s - RW'(1)) : pos_s;
    assign saved_s = $signed(RW'(count_reg));
    assign flip_off = (room_s < saved_s) && ((tp_s - room_s) > saved_s);

    assign is_off    = (req_reg == stg_pkg::REQ_NOTE_OFF) ||
                       ((req_reg == stg_pkg::REQ_NOTE_ON) && (vel_reg == '0));
    assign off_match = active_reg && (pitch_in_reg == pitch_reg);

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        pitch_next  = pitch_reg;
        half_next   = half_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        bit_next    = bit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (req_reg == stg_pkg::REQ_TICK) begin
                    if (active_reg) begin
                        accum_next = sum_sat;
                        if (unit_ge) begin
                            dir_next   = tog_dir;
                            phase_next = tog_phase;
                            pos_next   = tog_pos;
                            count_next = tog_count;
                            if (half_reg == '0) begin
                                accum_next = '0;
                            end else begin
                                rem_next   = '0;
                                bit_next   = '0;
                                state_next = ST_DIV;
                            end
                        end
                    end
                end else if (is_off) begin
                    if (off_match) begin
                        phase_next  = 1'b0;
                        active_next = 1'b0;
                        pitch_next  = '0;
                        half_next   = '0;
                        accum_next  = '0;
                        count_next  = '0;
                        dir_next    = dir_reg ^ flip_off;
                    end
                end else if (req_reg == stg_pkg::REQ_NOTE_ON) begin
                    active_next = 1'b1;
                    pitch_next  = pitch_in_reg;
                    half_next   = half_in_reg;
                end
            end
            ST_DIV: begin
                // one restoring remainder step per cycle, dividend shifts out of accum
                rem_next   = unit_ge ? unit_diff[CMP_W-1:0] : trial[CMP_W-1:0];
                accum_next = {accum_reg[TIME_WIDTH-2:0], 1'b0};
                bit_next   = bit_reg + 1'b1;
                if (bit_reg == CNT_W'(TIME_WIDTH - 1)) begin
                    accum_next = rem_next[TIME_WIDTH-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tp_reg      <= stg_pkg::TRACK_POSITIONS_RESET;
            phase_reg   <= 1'b0;
            dir_reg     <= 1'b1;
            pos_reg     <= '0;
            active_reg  <= 1'b0;
            pitch_reg   <= '0;
            half_reg    <= '0;
            accum_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
            pitch_reg  <= pitch_next;
            half_reg   <= half_next;
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            if (cfg_we) begin
                tp_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        if (s_valid && s_ready) begin
            req_reg      <= s_req_type;
            elapsed_reg  <= s_elapsed_time;
            pitch_in_reg <= s_note_pitch;
            vel_reg      <= s_velocity;
            half_in_reg  <= s_note_period[stg_pkg::PERIOD_W-1:1];
        end
        if (out_load) begin
            m_step_reg     <= phase_reg;
            m_dir_reg      <= dir_reg;
            m_pos_reg      <= pos_reg;
            m_sounding_reg <= active_reg;
            m_pitch_reg    <= pitch_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_step_level      = m_step_reg;
    assign m_direction_level = m_dir_reg;
    assign m_head_position   = m_pos_reg;
    assign m_sounding        = m_sounding_reg;
    assign m_playing_pitch   = m_pitch_reg;

endmodule

// ----- hw/rtl/stg_checker.sv -----
// Port-level checks for the stepper tone generator core, bound into the core module.
// Depends on stg_pkg and stepper_tone_generator_with_bounce_core.
module stg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_step_level,
    input logic                          m_direction_level,
    input logic [stg_pkg::POS_W-1:0]     m_head_position,
    input logic                          m_sounding,
    input logic [stg_pkg::PITCH_W-1:0]   m_playing_pitch
);

    // one item at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("core ready again one cycle after taking an item");

    // a result needs at least the execute cycle
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared one cycle after the item");

    // a silent head shows low step level and pitch zero
    a_silent_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sounding) |-> (!m_step_level && (m_playing_pitch == '0)))
        else $error("silent result shows step level or pitch");

    // hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_head_position)
                                   && $stable(m_step_level) && $stable(m_sounding)
                                   && $stable(m_direction_level)
                                   && $stable(m_playing_pitch)))
        else $error("stalled result changed");

endmodule

bind stepper_tone_generator_with_bounce_core stg_checker u_stg_checker (.*);

// ----- dv/tb_stepper_tone_generator_with_bounce_core.sv -----
`timescale 1ns / 100ps
// Testbench for stepper_tone_generator_with_bounce_core: tick and note items with a
// predicted head state per item, checked in order. Depends on stg_pkg and the core.
module tb_stepper_tone_generator_with_bounce_core;
    import stg_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int TIME_W        = TIME_WIDTH_DEF;
    localparam int STEP_W        = STEP_COUNT_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int PHASE_COUNT   = 7;

    typedef struct packed {
        logic               step_level;
        logic               direction_level;
        logic [POS_W-1:0]   head_position;
        logic               sounding;
        logic [PITCH_W-1:0] playing_pitch;
    } head_state_t;

    class tone_scoreboard;
        logic [POS_W-1:0]    tracks;
        logic                phase;
        logic                dir_up;
        logic [POS_W-1:0]    pos;
        logic                active;
        logic [PITCH_W-1:0]  pitch;
        logic [TIME_W-1:0]   half;
        logic [TIME_W-1:0]   accum;
        logic [STEP_W-1:0]   steps;
        head_state_t         head_states_due[$];
        int errors;
        int checked;
        int toggles;
        int bounces;
        int reversals;

        function new();
            tracks = TRACK_POSITIONS_RESET;
            dir_up = 1'b1;
            pos    = '0;
            stop_note();
            errors = 0;
            checked = 0;
            toggles = 0;
            bounces = 0;
            reversals = 0;
        endfunction

        function void set_tracks(logic [POS_W-1:0] v);
            tracks = v;
        endfunction

        function int pending();
            return head_states_due.size();
        endfunction

        function int room_ahead();
            if (dir_up)
                return int'(tracks) - int'(pos) - 1;
            return int'(pos);
        endfunction

        function void stop_note();
            phase  = 1'b0;
            active = 1'b0;
            pitch  = '0;
            half   = '0;
            accum  = '0;
            steps  = '0;
        endfunction

        function void toggle_step();
            toggles++;
            if (room_ahead() <= 0) begin
                dir_up = !dir_up;
                bounces++;
            end
            phase = !phase;
            if (phase) begin
                if (steps != '1)
                    steps++;
                if (dir_up) begin
                    if (pos != '1)
                        pos++;
                end else if (pos != '0) begin
                    pos--;
                end
            end
        endfunction

        function void release_note(logic [PITCH_W-1:0] p);
            int saved;
            int room;
            if (!active || p != pitch)
                return;
            saved = int'(steps);
            stop_note();
            room = room_ahead();
            // turn around when the room ahead is under the saved steps and tracks minus it is over
            if (room < saved && int'(tracks) - room > saved) begin
                dir_up = !dir_up;
                reversals++;
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [ELAPSED_W-1:0] elapsed,
                                   logic [PITCH_W-1:0] p, logic [VEL_W-1:0] vel,
                                   logic [PERIOD_W-1:0] period);
            logic [TIME_W:0] sum;
            head_state_t want;
            case (req)
                REQ_TICK: begin
                    if (active) begin
                        sum = {1'b0, accum} + elapsed;
                        if (sum > {1'b0, {TIME_W{1'b1}}})
                            sum = {1'b0, {TIME_W{1'b1}}};
                        accum = sum[TIME_W-1:0];
                        if (accum >= half) begin
                            toggle_step();
                            accum = (half == '0) ? '0 : accum % half;
                        end
                    end
                end
                REQ_NOTE_ON: begin
                    if (vel == '0) begin
                        release_note(p);
                    end else begin
                        active = 1'b1;
                        pitch  = p;
                        half   = TIME_W'(period >> 1);
                    end
                end
                REQ_NOTE_OFF: release_note(p);
                default: ;
            endcase
            want = {phase, dir_up, pos, active, active ? pitch : {PITCH_W{1'b0}}};
            head_states_due.push_back(want);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_head_state(head_state_t got);
            head_state_t want;
            if (head_states_due.size() == 0) begin
                report("result item with nothing outstanding");
                return;
            end
            want = head_states_due.pop_front();
            checked++;
            if (got.step_level !== want.step_level)
                report($sformatf("step_level %0b, want %0b", got.step_level, want.step_level));
            if (got.direction_level !== want.direction_level)
                report($sformatf("direction_level %0b, want %0b",
                                 got.direction_level, want.direction_level));
            if (got.head_position !== want.head_position)
                report($sformatf("head_position %0d, want %0d",
                                 got.head_position, want.head_position));
            if (got.sounding !== want.sounding)
                report($sformatf("sounding %0b, want %0b", got.sounding, want.sounding));
            if (got.playing_pitch !== want.playing_pitch)
                report($sformatf("playing_pitch %0d, want %0d",
                                 got.playing_pitch, want.playing_pitch));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [POS_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type;
    logic [ELAPSED_W-1:0] s_elapsed_time;
    logic [PITCH_W-1:0]   s_note_pitch;
    logic [VEL_W-1:0]     s_velocity;
    logic [PERIOD_W-1:0]  s_note_period;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_step_level;
    logic                 m_direction_level;
    logic [POS_W-1:0]     m_head_position;
    logic                 m_sounding;
    logic [PITCH_W-1:0]   m_playing_pitch;

    tone_scoreboard sb;
    head_state_t    observed;
    logic           steady;
    int             items_sent;
    int             cycles;
    int             stall_left;

    stepper_tone_generator_with_bounce_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_elapsed_time    (s_elapsed_time),
        .s_note_pitch      (s_note_pitch),
        .s_velocity        (s_velocity),
        .s_note_period     (s_note_period),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_step_level      (m_step_level),
        .m_direction_level (m_direction_level),
        .m_head_position   (m_head_position),
        .m_sounding        (m_sounding),
        .m_playing_pitch   (m_playing_pitch)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("tb_stepper_tone_generator_with_bounce_core: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls on m_ready
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed = {m_step_level, m_direction_level, m_head_position,
                        m_sounding, m_playing_pitch};
            sb.check_head_state(observed);
        end
    end

    function automatic logic [PITCH_W-1:0] rand7();
        return PITCH_W'($urandom);
    endfunction

    function automatic logic [ELAPSED_W-1:0] rand16();
        return ELAPSED_W'($urandom);
    endfunction

    function automatic logic [PERIOD_W-1:0] rand20();
        return PERIOD_W'($urandom);
    endfunction

    function automatic logic [PERIOD_W-1:0] rand_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return PERIOD_W'($urandom_range(0, 1));
        if (r < 60)
            return PERIOD_W'($urandom_range(2, 40));
        if (r < 85)
            return PERIOD_W'($urandom_range(41, 4000));
        return rand20();
    endfunction

    function automatic logic [ELAPSED_W-1:0] rand_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return ELAPSED_W'($urandom_range(0, 30));
        if (r < 80)
            return ELAPSED_W'($urandom_range(0, 2000));
        return rand16();
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ELAPSED_W-1:0] elapsed,
                                input logic [PITCH_W-1:0] p, input logic [VEL_W-1:0] vel,
                                input logic [PERIOD_W-1:0] period);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_elapsed_time <= elapsed;
        s_note_pitch   <= p;
        s_velocity     <= vel;
        s_note_period  <= period;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, elapsed, p, vel, period);
        items_sent++;
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_request(REQ_TICK, rand_elapsed(), rand7(), rand7(), rand20());
            1: send_request(REQ_NOTE_OFF, rand16(), rand7(), rand7(), rand20());
            default: send_request(REQ_UNUSED, rand16(), rand7(), rand7(), rand20());
        endcase
    endtask

    // note on, a run of ticks mixed with new notes, stray note offs and noise, then usually a note off
    task automatic play_phrase();
        logic [PITCH_W-1:0]  tone;
        logic [PERIOD_W-1:0] period;
        int length;
        int k;
        int r;
        steady = ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 4) == 0)
            send_noise();
        tone   = rand7();
        period = rand_period();
        length = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
        send_request(REQ_NOTE_ON, rand16(), tone, VEL_W'($urandom_range(1, 127)), period);
        for (k = 0; k < length; k++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                send_request(REQ_TICK, rand_elapsed(), rand7(), rand7(), rand20());
            end else if (r < 93) begin
                if ($urandom_range(0, 1) == 1)
                    tone = rand7();
                send_request(REQ_NOTE_ON, rand16(), tone, VEL_W'($urandom_range(1, 127)),
                             rand_period());
            end else if (r < 97) begin
                send_request(REQ_NOTE_OFF, rand16(), tone + PITCH_W'($urandom_range(1, 127)),
                             rand7(), rand20());
            end else begin
                send_noise();
            end
        end
        r = $urandom_range(0, 9);
        if (r < 5)
            send_request(REQ_NOTE_OFF, rand16(), tone, rand7(), rand20());
        else if (r < 9)
            send_request(REQ_NOTE_ON, rand16(), tone, '0, rand20());
    endtask

    // wait for every result, then let the core go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tracks(input logic [POS_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_tracks(v);
    endtask

    function automatic logic [POS_W-1:0] planned_tracks(int idx);
        case (idx)
            0: return 8'd2;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd0;
            4: return 8'd3;
            5: return 8'd80;
            default: return POS_W'($urandom_range(2, 255));
        endcase
    endfunction

    function automatic int planned_items(int idx);
        case (idx)
            1: return 700;
            2, 3: return 120;
            default: return 200;
        endcase
    endfunction

    initial begin
        int goal;
        int idx;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_req_type     = REQ_TICK;
        s_elapsed_time = '0;
        s_note_pitch   = '0;
        s_velocity     = '0;
        s_note_period  = '0;
        m_ready        = 1'b0;
        steady         = 1'b0;
        items_sent     = 0;
        cycles         = 0;
        stall_left     = 0;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // silent tick, stray note off, unused code, all fields at their top
        send_request(REQ_TICK, '1, '1, '1, '1);
        send_request(REQ_NOTE_OFF, '1, '1, '1, '1);
        send_request(REQ_UNUSED, '1, '1, '1, '1);
        send_request(REQ_NOTE_ON, '0, '1, '1, '1);
        send_request(REQ_TICK, '1, '0, '0, '0);
        // replace the note, keep the time sum
        send_request(REQ_NOTE_ON, '0, '0, 7'd1, 20'd2);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_TICK, 16'd1, '0, '0, '0);
        send_request(REQ_NOTE_OFF, '0, 7'd5, '0, '0);
        // zero half period from periods of 0 and 1
        send_request(REQ_NOTE_ON, '0, '0, '1, 20'd0);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_NOTE_ON, '0, '0, '1, 20'd1);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_NOTE_ON, '0, '0, '0, '0);
        send_request(REQ_NOTE_ON, '0, 7'd64, 7'd64, 20'd3);
        send_request(REQ_TICK, 16'd1, '0, '0, '0);
        send_request(REQ_NOTE_OFF, '0, 7'd64, '0, '0);
        send_request(REQ_NOTE_ON, '0, 7'd33, 7'd10, 20'd1000);
        send_request(REQ_TICK, '0, '0, '0, '0);
        send_request(REQ_NOTE_OFF, '0, 7'd33, '0, '0);

        goal = 250;
        while (items_sent < goal)
            play_phrase();
        for (idx = 0; idx < PHASE_COUNT; idx++) begin
            settle();
            write_tracks(planned_tracks(idx));
            goal += planned_items(idx);
            while (items_sent < goal)
                play_phrase();
        end
        steady = 1'b0;
        settle();

        $display("Sent %0d items over %0d track settings, checked %0d results.",
                 items_sent, PHASE_COUNT + 1, sb.checked);
        $display("Saw %0d step toggles, %0d end-of-travel bounces, %0d note-off reversals.",
                 sb.toggles, sb.bounces, sb.reversals);
        if (sb.errors == 0)
            $display("tb_stepper_tone_generator_with_bounce_core: clean");
        else
            $display("tb_stepper_tone_generator_with_bounce_core: errors");
        $finish;
    end

endmodule
